// ----- rtl/gbbe_pkg.sv -----
package gbbe_pkg;

    // Field widths fixed by the item format
    localparam int COORD_W = 3;
    localparam int STEPS_W = 4;
    localparam int MAP_W   = 64;
    localparam int COUNT_W = 7;
    localparam int DIST_W  = 4;
    localparam int MODE_W  = 3;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRUNE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEAREST   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [STEPS_W-1:0] dilate_steps;
        logic [MAP_W-1:0]   data_mask;
    } in_item_t;

    typedef struct packed {
        logic [MAP_W-1:0]   belief_out;
        logic [COUNT_W-1:0] cell_count;
        logic [COORD_W-1:0] near_x;
        logic [COORD_W-1:0] near_y;
        logic               found;
        logic               accepted;
    } out_item_t;

    // Row update applied by every cell at once
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DILATE,
        OP_PRUNE,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
    } ctrl_t;

    // Partial result handed from cell to cell during a sweep
    typedef struct packed {
        logic [COUNT_W-1:0] cnt_cur;
        logic [COUNT_W-1:0] cnt_cand;
        logic               found;
        logic [DIST_W-1:0]  best_dist;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
    } acc_t;

endpackage

// ----- rtl/gbbe_cell.sv -----
module gbbe_cell #(
    parameter int BOARD_SIZE = 8,
    parameter int ROW_IDX    = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbbe_pkg::ctrl_t       ctrl,
    input  logic [BOARD_SIZE-1:0] data_row,
    input  logic [BOARD_SIZE-1:0] obst_row,
    input  logic [BOARD_SIZE-1:0] up_row,
    input  logic [BOARD_SIZE-1:0] down_row,
    input  gbbe_pkg::acc_t        acc_in,
    output logic [BOARD_SIZE-1:0] row,
    output gbbe_pkg::acc_t        acc_out
);

    logic [BOARD_SIZE-1:0]        row_reg;
    logic [BOARD_SIZE-1:0]        row_next;
    logic [BOARD_SIZE-1:0]        me_row;
    logic [BOARD_SIZE-1:0]        blocked;
    logic [BOARD_SIZE-1:0]        grown;
    logic [BOARD_SIZE-1:0]        cand_row;
    logic [gbbe_pkg::COUNT_W-1:0] cnt_cur;
    logic [gbbe_pkg::COUNT_W-1:0] cnt_cand;
    logic                         row_found;
    logic [gbbe_pkg::COORD_W-1:0] best_dx;
    logic [gbbe_pkg::COORD_W-1:0] best_x;
    logic [gbbe_pkg::COORD_W-1:0] dy;
    logic [gbbe_pkg::DIST_W-1:0]  row_dist;
    gbbe_pkg::acc_t               acc_reg;
    gbbe_pkg::acc_t               acc_next;

    localparam logic [gbbe_pkg::COORD_W-1:0] ROW_Y = gbbe_pkg::COORD_W'(ROW_IDX);

    // Mark the own position when it falls in this row
    always_comb
    begin
        for (int x = 0; x < BOARD_SIZE; x++)
        begin
            me_row[x] = (ctrl.qy == ROW_Y) && (ctrl.qx == gbbe_pkg::COORD_W'(x));
        end
    end

    assign blocked  = obst_row | me_row;
    assign grown    = (row_reg << 1) | (row_reg >> 1) | up_row | down_row;
    assign cand_row = row_reg & data_row;

    // Update the row held by this cell
    always_comb
    begin
        unique case (ctrl.op)
            gbbe_pkg::OP_HOLD:   row_next = row_reg;
            gbbe_pkg::OP_LOAD:   row_next = data_row;
            gbbe_pkg::OP_DILATE: row_next = row_reg | (grown & ~blocked);
            gbbe_pkg::OP_PRUNE:  row_next = row_reg & ~blocked;
            gbbe_pkg::OP_COMMIT: row_next = cand_row;
            default:             row_next = row_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    // Count set cells and find the closest column to the query point
    always_comb
    begin
        logic [gbbe_pkg::COORD_W-1:0] xc;
        logic [gbbe_pkg::COORD_W-1:0] dx;
        cnt_cur   = '0;
        cnt_cand  = '0;
        row_found = 1'b0;
        best_dx   = '0;
        best_x    = '0;
        for (int x = 0; x < BOARD_SIZE; x++)
        begin
            xc       = gbbe_pkg::COORD_W'(x);
            dx       = (xc >= ctrl.qx) ? (xc - ctrl.qx) : (ctrl.qx - xc);
            cnt_cur  = cnt_cur + gbbe_pkg::COUNT_W'(row_reg[x]);
            cnt_cand = cnt_cand + gbbe_pkg::COUNT_W'(cand_row[x]);
            if (row_reg[x] && (!row_found || dx < best_dx))
            begin
                row_found = 1'b1;
                best_dx   = dx;
                best_x    = xc;
            end
        end
    end

    assign dy       = (ROW_Y >= ctrl.qy) ? (ROW_Y - ctrl.qy) : (ctrl.qy - ROW_Y);
    assign row_dist = gbbe_pkg::DIST_W'(best_dx) + gbbe_pkg::DIST_W'(dy);

    // Fold this row into the partial result; earlier rows win ties
    always_comb
    begin
        acc_next          = acc_in;
        acc_next.cnt_cur  = acc_in.cnt_cur + cnt_cur;
        acc_next.cnt_cand = acc_in.cnt_cand + cnt_cand;
        if (row_found && (!acc_in.found || row_dist < acc_in.best_dist))
        begin
            acc_next.found     = 1'b1;
            acc_next.best_dist = row_dist;
            acc_next.nx        = best_x;
            acc_next.ny        = ROW_Y;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign row     = row_reg;
    assign acc_out = acc_reg;

endmodule

// ----- rtl/grid_belief_bitmap_engine_top.sv -----
// Bitmap engine holding a BOARD_SIZE x BOARD_SIZE map of possible cells, one row per
// cell of a chain. Each input transaction runs one operation (load, dilate, prune,
// intersect, nearest, read) and returns exactly one result transaction. An item is
// accepted in S_IDLE, updates the rows in S_APPLY (one dilation step per cycle, done
// by all row cells in parallel), sweeps the count and nearest search down the chain
// of row cells in S_SWEEP, and posts the result in S_DONE; a stalled earlier result
// holds the item in S_DONE until it is taken. One item is in flight at a time; the next
// item is taken while the result waits. The obstacle mask is written through the cfg
// channel, which is always ready.
module grid_belief_bitmap_engine_top #(
    parameter int BOARD_SIZE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  gbbe_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output gbbe_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbbe_pkg::MAP_W-1:0]     cfg_data
);

    localparam int SWEEP_W = $clog2(BOARD_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t                       state_reg;
    logic [gbbe_pkg::STEPS_W-1:0] steps_reg;
    logic [SWEEP_W-1:0]           sweep_cnt_reg;
    logic [gbbe_pkg::MAP_W-1:0]   obstacle_reg;
    logic                         out_valid_reg;
    gbbe_pkg::in_item_t           item_reg;
    gbbe_pkg::out_item_t          out_reg;

    gbbe_pkg::ctrl_t              ctrl;
    gbbe_pkg::acc_t               acc_w [BOARD_SIZE+1];
    logic [BOARD_SIZE-1:0]        rows  [BOARD_SIZE];
    logic [gbbe_pkg::MAP_W-1:0]   map_vec;
    logic [gbbe_pkg::MAP_W-1:0]   cand_vec;
    logic                         in_fire;
    logic                         out_free;
    logic                         commit;
    logic                         is_intersect;
    logic                         is_nearest;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign is_intersect = (item_reg.mode == gbbe_pkg::MODE_INTERSECT);
    assign is_nearest   = (item_reg.mode == gbbe_pkg::MODE_NEAREST);
    assign commit       = is_intersect && (acc_w[BOARD_SIZE].cnt_cand != '0);

    // Drive the row operation for all cells
    always_comb
    begin
        ctrl.qx = item_reg.pos_x;
        ctrl.qy = item_reg.pos_y;
        ctrl.op = gbbe_pkg::OP_HOLD;
        if (state_reg == S_APPLY)
        begin
            priority if (item_reg.mode == gbbe_pkg::MODE_LOAD)
                ctrl.op = gbbe_pkg::OP_LOAD;
            else if (item_reg.mode == gbbe_pkg::MODE_DILATE && steps_reg != '0)
                ctrl.op = gbbe_pkg::OP_DILATE;
            else if (item_reg.mode == gbbe_pkg::MODE_PRUNE)
                ctrl.op = gbbe_pkg::OP_PRUNE;
            else
                ctrl.op = gbbe_pkg::OP_HOLD;
        end
        else if (state_reg == S_DONE && out_free && commit)
        begin
            ctrl.op = gbbe_pkg::OP_COMMIT;
        end
    end

    assign acc_w[0] = '0;

    // Chain of row cells; each sees the rows above and below
    for (genvar r = 0; r < BOARD_SIZE; r++)
    begin : g_row
        logic [BOARD_SIZE-1:0] up_row;
        logic [BOARD_SIZE-1:0] down_row;

        if (r == 0)
        begin : g_top
            assign up_row = '0;
        end
        else
        begin : g_mid_up
            assign up_row = rows[r-1];
        end

        if (r == BOARD_SIZE - 1)
        begin : g_bottom
            assign down_row = '0;
        end
        else
        begin : g_mid_down
            assign down_row = rows[r+1];
        end

        gbbe_cell #(
            .BOARD_SIZE (BOARD_SIZE),
            .ROW_IDX    (r)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .data_row (item_reg.data_mask[r*BOARD_SIZE +: BOARD_SIZE]),
            .obst_row (obstacle_reg[r*BOARD_SIZE +: BOARD_SIZE]),
            .up_row   (up_row),
            .down_row (down_row),
            .acc_in   (acc_w[r]),
            .row      (rows[r]),
            .acc_out  (acc_w[r+1])
        );
    end

    // Gather rows into the flat bitmap
    always_comb
    begin
        map_vec = '0;
        for (int r = 0; r < BOARD_SIZE; r++)
        begin
            map_vec[r*BOARD_SIZE +: BOARD_SIZE] = rows[r];
        end
    end

    assign cand_vec = map_vec & item_reg.data_mask;

    // Sequence one transaction: apply, sweep, post result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= '0;
            sweep_cnt_reg <= '0;
            obstacle_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                obstacle_reg <= cfg_data;
            end

            // Raise valid when a result posts, drop it once taken
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        steps_reg <= in_data.dilate_steps;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (item_reg.mode == gbbe_pkg::MODE_DILATE && steps_reg > 1)
                    begin
                        steps_reg <= steps_reg - 1'b1;
                    end
                    else
                    begin
                        sweep_cnt_reg <= '0;
                        state_reg     <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    if (sweep_cnt_reg == SWEEP_W'(BOARD_SIZE - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the item payload and the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_reg.belief_out <= commit ? cand_vec : map_vec;
            out_reg.cell_count <= commit ? acc_w[BOARD_SIZE].cnt_cand
                                         : acc_w[BOARD_SIZE].cnt_cur;
            out_reg.found      <= is_nearest && acc_w[BOARD_SIZE].found;
            out_reg.near_x     <= (is_nearest && acc_w[BOARD_SIZE].found)
                                  ? acc_w[BOARD_SIZE].nx : '0;
            out_reg.near_y     <= (is_nearest && acc_w[BOARD_SIZE].found)
                                  ? acc_w[BOARD_SIZE].ny : '0;
            out_reg.accepted   <= !(is_intersect && !commit);
        end
    end

endmodule
